/* sv/clns_pkg.sv */
`timescale 1ns / 1ps
package clns_pkg;

  localparam int KIND_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int NIB_W    = 4;
  localparam int PAUSE_W  = 16;
  localparam int WAIT_W   = 17;
  localparam int CIDX_W   = 3;
  localparam int STEP_W   = 4;

  localparam logic [NIB_W-1:0]  WAKE_NIBBLE      = 4'h3;
  localparam logic [NIB_W-1:0]  FOUR_BIT_NIBBLE  = 4'h2;
  localparam logic [BYTE_W-1:0] DISPLAY_OFF_CODE = 8'h08;

  localparam logic [STEP_W-1:0] BYTE_LAST_STEP = 4'd1;
  localparam logic [STEP_W-1:0] INIT_LAST_STEP = 4'd8;

  // request kinds as seen on the input word
  typedef enum logic [KIND_W-1:0] {
    KIND_DATA    = 2'd0,
    KIND_COMMAND = 2'd1,
    KIND_INIT    = 2'd2
  } kind_t;

  // configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    CFG_DATA_PAUSE        = 3'd0,
    CFG_COMMAND_PAUSE     = 3'd1,
    CFG_WAKE_PAUSE_FIRST  = 3'd2,
    CFG_WAKE_PAUSE_SECOND = 3'd3,
    CFG_INIT_STEP_PAUSE   = 3'd4,
    CFG_FUNCTION_SET_CODE = 3'd5,
    CFG_DISPLAY_ON_CODE   = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic [PAUSE_W-1:0] data_pause;
    logic [PAUSE_W-1:0] command_pause;
    logic [PAUSE_W-1:0] wake_pause_first;
    logic [PAUSE_W-1:0] wake_pause_second;
    logic [PAUSE_W-1:0] init_step_pause;
    logic [BYTE_W-1:0]  function_set_code;
    logic [BYTE_W-1:0]  display_on_code;
  } cfg_t;

  // one classified request in the queue
  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] value;
  } op_t;

  // queue status toward front and back
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

/* sv/clns_if.sv */
`timescale 1ns / 1ps
interface clns_req_if;
  import clns_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] value;
  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

interface clns_strobe_if;
  import clns_pkg::*;
  logic              valid;
  logic              ready;
  logic [NIB_W-1:0]  nibble;
  logic              register_select;
  logic [WAIT_W-1:0] wait_after;
  logic              last;
  modport source (output valid, nibble, register_select, wait_after, last, input ready);
  modport sink   (input valid, nibble, register_select, wait_after, last, output ready);
endinterface

interface clns_cfg_if;
  import clns_pkg::*;
  logic               valid;
  logic               ready;
  logic [CIDX_W-1:0]  index;
  logic [PAUSE_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/clns_cfg_regs.sv */
`timescale 1ns / 1ps
module clns_cfg_regs
  import clns_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  clns_cfg_if.sink   cfg,
  output cfg_t       regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.data_pause        <= 16'd200;
      regs.command_pause     <= 16'd3000;
      regs.wake_pause_first  <= 16'd15000;
      regs.wake_pause_second <= 16'd500;
      regs.init_step_pause   <= 16'd1000;
      regs.function_set_code <= 8'h28;
      regs.display_on_code   <= 8'h0c;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_index_t'(cfg.index))
        CFG_DATA_PAUSE:        regs.data_pause        <= cfg.data;
        CFG_COMMAND_PAUSE:     regs.command_pause     <= cfg.data;
        CFG_WAKE_PAUSE_FIRST:  regs.wake_pause_first  <= cfg.data;
        CFG_WAKE_PAUSE_SECOND: regs.wake_pause_second <= cfg.data;
        CFG_INIT_STEP_PAUSE:   regs.init_step_pause   <= cfg.data;
        CFG_FUNCTION_SET_CODE: regs.function_set_code <= cfg.data[BYTE_W-1:0];
        CFG_DISPLAY_ON_CODE:   regs.display_on_code   <= cfg.data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/clns_front.sv */
`timescale 1ns / 1ps
module clns_front
  import clns_pkg::*;
(
  clns_req_if.sink  req,
  input  q_stat_t   q_stat,
  output logic      push,
  output op_t       push_op
);

  logic known;

  // unused kind is taken and dropped
  assign known = req.kind inside {KIND_DATA, KIND_COMMAND, KIND_INIT};

  assign req.ready     = !q_stat.full;
  assign push          = req.valid && !q_stat.full && known;
  assign push_op.kind  = kind_t'(req.kind);
  assign push_op.value = req.value;

endmodule

/* sv/clns_queue.sv */
`timescale 1ns / 1ps
module clns_queue
  import clns_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  op_t     push_op,
  input  logic    pop,
  output op_t     head,
  output q_stat_t q_stat
);

  op_t        mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head         = mem[rd_ptr];
  assign q_stat.empty = (count == 2'd0);
  assign q_stat.full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/clns_back.sv */
`timescale 1ns / 1ps
module clns_back
  import clns_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         regs,
  input  op_t          head,
  input  q_stat_t      q_stat,
  output logic         pop,
  clns_strobe_if.source strobe
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              load;
  logic              out_valid;
  logic              out_valid_next;
  logic [WAIT_W-1:0] step_wait;
  logic [NIB_W-1:0]  nib_c;
  logic              rs_c;
  logic [WAIT_W-1:0] wait_c;
  logic              last_c;

  assign step_wait = {1'b0, regs.command_pause} + {1'b0, regs.init_step_pause};

  // strobe for the current head item at the current step
  always_comb begin
    nib_c  = head.value[BYTE_W-1:NIB_W];
    rs_c   = 1'b0;
    wait_c = '0;
    last_c = 1'b0;
    case (head.kind)
      KIND_DATA, KIND_COMMAND: begin
        rs_c = (head.kind == KIND_DATA);
        if (step == BYTE_LAST_STEP) begin
          nib_c  = head.value[NIB_W-1:0];
          wait_c = (head.kind == KIND_DATA) ? {1'b0, regs.data_pause}
                                            : {1'b0, regs.command_pause};
          last_c = 1'b1;
        end
      end
      KIND_INIT: begin
        case (step)
          4'd0: begin
            nib_c  = WAKE_NIBBLE;
            wait_c = {1'b0, regs.wake_pause_first};
          end
          4'd1: begin
            nib_c  = WAKE_NIBBLE;
            wait_c = {1'b0, regs.wake_pause_second};
          end
          4'd2: begin
            nib_c  = FOUR_BIT_NIBBLE;
            wait_c = {1'b0, regs.init_step_pause};
          end
          4'd3: nib_c = regs.function_set_code[BYTE_W-1:NIB_W];
          4'd4: begin
            nib_c  = regs.function_set_code[NIB_W-1:0];
            wait_c = step_wait;
          end
          4'd5: nib_c = DISPLAY_OFF_CODE[BYTE_W-1:NIB_W];
          4'd6: begin
            nib_c  = DISPLAY_OFF_CODE[NIB_W-1:0];
            wait_c = step_wait;
          end
          4'd7: nib_c = regs.display_on_code[BYTE_W-1:NIB_W];
          default: begin
            nib_c  = regs.display_on_code[NIB_W-1:0];
            wait_c = step_wait;
            last_c = 1'b1;
          end
        endcase
      end
      default: ;
    endcase
  end

  assign load = !q_stat.empty && (!out_valid || strobe.ready);
  assign pop  = load && last_c;

  always_comb begin
    step_next = step;
    if (load) begin
      step_next = last_c ? '0 : step + 4'd1;
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (strobe.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      strobe.nibble          <= nib_c;
      strobe.register_select <= rs_c;
      strobe.wait_after      <= wait_c;
      strobe.last            <= last_c;
    end
  end

  assign strobe.valid = out_valid;

  // mid-item step needs its item still at the head
  a_step_has_item: assert property (@(posedge clk) disable iff (rst)
    (step != 4'd0) |-> !q_stat.empty)
    else $error("step advanced with empty queue");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step <= INIT_LAST_STEP)
    else $error("step past last init strobe");

  a_byte_steps: assert property (@(posedge clk) disable iff (rst)
    (!q_stat.empty && head.kind != KIND_INIT) |-> step <= BYTE_LAST_STEP)
    else $error("byte request beyond two strobes");

  a_pop_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> (strobe.valid && strobe.last && step == 4'd0))
    else $error("pop without final strobe loaded");

endmodule

/* sv/char_lcd_nibble_sequencer_top.sv */
`timescale 1ns / 1ps
// 4-bit character lcd sequencer
// req channel: one word per request (kind: data byte, command byte, initialise;
//   value: byte to send). kind 3 is taken and produces nothing.
// strobe channel: one word per enable strobe: nibble, register_select, the
//   pause ticks to hold after it, and last on the final strobe of a request.
// cfg channel: register index and data, always ready; write only while idle.
// throughput: one strobe per cycle out of the back end's output register while
//   the receiver is ready: two strobes per byte request, nine per initialise.
// path: with the queue and output register empty, an accepted request is first
//   written into the queue, then its first strobe is loaded from the queue head
//   into the output register, where the strobe receiver can take it.
// a two-word queue sits between the front classifier and the back sequencer;
//   req stays ready while the queue has room, even when the strobe receiver
//   stalls and a strobe waits in the output register.
// reset: queue and sequencer empty, no strobe valid, registers at defaults.
module char_lcd_nibble_sequencer_top
  import clns_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  clns_req_if.sink      req,
  clns_strobe_if.source strobe,
  clns_cfg_if.sink      cfg
);

  cfg_t    regs;
  q_stat_t q_stat;
  logic    push;
  logic    pop;
  op_t     push_op;
  op_t     head;

  // pause and code registers
  clns_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // front: accept and classify requests
  clns_front u_front (
    .req     (req),
    .q_stat  (q_stat),
    .push    (push),
    .push_op (push_op)
  );

  // decoupling queue
  clns_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .q_stat  (q_stat)
  );

  // back: expand each request into strobes
  clns_back u_back (
    .clk    (clk),
    .rst    (rst),
    .regs   (regs),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .strobe (strobe)
  );

endmodule
